>>> rtl/usw_pkg.sv
package usw_pkg;

    // request opcodes
    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_END_WORD = 2'd1;
    localparam logic [1:0] OP_END_LIST = 2'd2;
    localparam logic [1:0] OP_PULL     = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] ch;
    } req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_word;
        logic       last_of_list;
        logic       empty_res;
        logic       dropped;
    } rsp_t;

    // order memory read address select
    typedef enum logic [1:0] {
        ORD_SEL_P  = 2'd0,
        ORD_SEL_Q1 = 2'd1,
        ORD_SEL_RW = 2'd2
    } ord_sel_t;

    // outcome of one compare step between a stored word and the pending word
    typedef enum logic [1:0] {
        CMP_MATCH   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2,
        CMP_EQUAL   = 2'd3
    } cmp_t;

    typedef struct packed {
        logic     push;
        logic     scan_init;
        logic     col_inc;
        logic     next_word;
        logic     ld_base;
        logic     base_cnt;
        logic     char_wr;
        logic     len_wr;
        logic     q_init;
        logic     q_dec;
        ord_sel_t ord_sel;
        logic     ord_wr;
        logic     ord_ins;
        logic     commit;
        logic     fin;
        logic     fin_sort;
        logic     set_drop;
        logic     addr_pull;
        logic     out_empty;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic plen_zero;
        logic cnt_zero;
        logic full;
        logic p_last;
        cmp_t cmp;
        logic wr_last;
        logic q_at_p;
        logic pull_empty;
        logic out_valid;
        logic sorted;
    } sts_t;

endpackage

>>> rtl/unique_sorted_word_list_unit.sv
// operation: a push adds its byte to the pending word; a word end compares it byte by
//   byte against stored words in order, then, if new, writes its bytes and length and
//   shifts the order list; a pull reads the order, loads the base, reads a byte and loads
//   the output, or gives an empty beat when nothing is left to pull; beats are taken one
//   at a time, and word end cost is set by the single-port compare up to the slot and the order shift
// reset: rst_n async active low clears control, counters and flags; word stores are
//   not cleared, nothing is read before it is written, no clearing pass
module unique_sorted_word_list_unit #(
    parameter int MAX_WORDS = 1024,
    parameter int MAX_LEN   = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    // request beats: push byte, end of word, end of list, pull
    input  logic          req_valid,
    output logic          req_stall,
    input  usw_pkg::req_t req,
    // response beats, one per pull
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output usw_pkg::rsp_t rsp
);

    usw_pkg::cmd_t cmd;
    usw_pkg::sts_t sts;

    // controller sequences scan, insert and pull steps
    usw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .req_stall  (req_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath holds the byte store, length store, sorted order list and output beat
    usw_dp #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req.ch),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> rtl/usw_ctrl.sv
module usw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    req_opcode,
    output logic          req_stall,
    input  usw_pkg::sts_t sts,
    output usw_pkg::cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_ORD  = 15'b000000000000010,
        S_ROW  = 15'b000000000000100,
        S_RD   = 15'b000000000001000,
        S_CMP  = 15'b000000000010000,
        S_INS  = 15'b000000000100000,
        S_WR   = 15'b000000001000000,
        S_SCHK = 15'b000000010000000,
        S_SRD  = 15'b000000100000000,
        S_SWR  = 15'b000001000000000,
        S_FIN  = 15'b000010000000000,
        S_PORD = 15'b000100000000000,
        S_PROW = 15'b001000000000000,
        S_PRD  = 15'b010000000000000,
        S_POUT = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       list_end_reg, list_end_next;
    logic       accept;

    assign req_stall = (state_reg != S_IDLE)
                     || (sts.out_valid && (req_opcode == usw_pkg::OP_PULL));
    assign accept = req_valid && !req_stall;

    always_comb
    begin
        state_next    = state_reg;
        list_end_next = list_end_reg;
        cmd           = '0;
        cmd.ord_sel   = usw_pkg::ORD_SEL_P;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_opcode == usw_pkg::OP_PULL)
                    begin
                        if (sts.pull_empty)
                            cmd.out_empty = 1'b1;
                        else
                            state_next = S_PORD;
                    end
                    else if (!sts.sorted)
                    begin
                        if (req_opcode == usw_pkg::OP_PUSH)
                            cmd.push = 1'b1;
                        else
                        begin
                            list_end_next = (req_opcode == usw_pkg::OP_END_LIST);
                            if (sts.plen_zero)
                                state_next = S_FIN;
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next = sts.cnt_zero ? S_INS : S_ORD;
                            end
                        end
                    end
                end
            end
            S_ORD:  state_next = S_ROW;
            S_ROW:
            begin
                cmd.ld_base = 1'b1;
                state_next  = S_RD;
            end
            S_RD:   state_next = S_CMP;
            S_CMP:
            begin
                unique case (sts.cmp)
                    usw_pkg::CMP_MATCH:
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = S_RD;
                    end
                    usw_pkg::CMP_LESS:
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = sts.p_last ? S_INS : S_ORD;
                    end
                    usw_pkg::CMP_GREATER: state_next = S_INS;
                    usw_pkg::CMP_EQUAL:   state_next = S_FIN;
                    default:              state_next = S_FIN;
                endcase
            end
            S_INS:
            begin
                if (sts.full)
                begin
                    cmd.set_drop = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.ld_base  = 1'b1;
                    cmd.base_cnt = 1'b1;
                    cmd.len_wr   = 1'b1;
                    cmd.q_init   = 1'b1;
                    state_next   = S_WR;
                end
            end
            S_WR:
            begin
                cmd.char_wr = 1'b1;
                cmd.col_inc = 1'b1;
                if (sts.wr_last)
                    state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (sts.q_at_p)
                begin
                    cmd.ord_wr  = 1'b1;
                    cmd.ord_ins = 1'b1;
                    cmd.commit  = 1'b1;
                    state_next  = S_FIN;
                end
                else
                    state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.ord_sel = usw_pkg::ORD_SEL_Q1;
                state_next  = S_SWR;
            end
            S_SWR:
            begin
                cmd.ord_wr = 1'b1;
                cmd.q_dec  = 1'b1;
                state_next = S_SCHK;
            end
            S_FIN:
            begin
                cmd.fin      = 1'b1;
                cmd.fin_sort = list_end_reg;
                state_next   = S_IDLE;
            end
            S_PORD:
            begin
                cmd.ord_sel = usw_pkg::ORD_SEL_RW;
                state_next  = S_PROW;
            end
            S_PROW:
            begin
                cmd.ord_sel = usw_pkg::ORD_SEL_RW;
                cmd.ld_base = 1'b1;
                state_next  = S_PRD;
            end
            S_PRD:
            begin
                cmd.ord_sel   = usw_pkg::ORD_SEL_RW;
                cmd.addr_pull = 1'b1;
                state_next    = S_POUT;
            end
            S_POUT:
            begin
                cmd.ord_sel   = usw_pkg::ORD_SEL_RW;
                cmd.addr_pull = 1'b1;
                cmd.out_load  = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            list_end_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            list_end_reg <= list_end_next;
        end
    end

endmodule

>>> rtl/usw_dp.sv
module usw_dp #(
    parameter int MAX_WORDS = 1024,
    parameter int MAX_LEN   = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    req_ch,
    input  usw_pkg::cmd_t cmd,
    output usw_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output usw_pkg::rsp_t rsp
);

    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int IW  = $clog2(MAX_WORDS);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int PIW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW  = (MAX_WORDS * MAX_LEN > 2) ? $clog2(MAX_WORDS * MAX_LEN) : 1;

    logic [7:0]    char_mem [MAX_WORDS * MAX_LEN];
    logic [LW-1:0] len_mem  [MAX_WORDS];
    logic [IW-1:0] ord_mem  [MAX_WORDS];

    logic [7:0]    pend_reg [MAX_LEN];
    logic [LW-1:0] plen_reg;
    logic [CW-1:0] count_reg, p_reg, q_reg, rword_reg;
    logic [LW-1:0] col_reg, rchar_reg;
    logic [AW-1:0] base_reg;
    logic          sorted_reg, drop_reg;
    logic          out_valid_reg;
    usw_pkg::rsp_t out_reg;

    logic [7:0]    char_rd_reg;
    logic [LW-1:0] len_rd_reg;
    logic [IW-1:0] ord_rd_reg;

    logic [PIW-1:0] pidx;
    logic [7:0]     pend_byte;
    logic [AW-1:0]  caddr;
    logic [CW-1:0]  ord_raddr;
    logic [CW-1:0]  mul_in;
    logic [LW-1:0]  cmp_n;
    logic           rd_last;
    logic           rsp_take;

    assign pidx      = (col_reg < LW'(MAX_LEN)) ? col_reg[PIW-1:0] : '0;
    assign pend_byte = pend_reg[pidx];
    assign caddr     = base_reg + AW'(cmd.addr_pull ? rchar_reg : col_reg);
    assign mul_in    = cmd.base_cnt ? count_reg : CW'(ord_rd_reg);
    assign cmp_n     = (len_rd_reg < plen_reg) ? len_rd_reg : plen_reg;
    assign rd_last   = (rchar_reg + LW'(1)) == len_rd_reg;
    assign rsp_take  = out_valid_reg && !rsp_stall;

    always_comb
    begin
        unique case (cmd.ord_sel)
            usw_pkg::ORD_SEL_Q1: ord_raddr = q_reg - CW'(1);
            usw_pkg::ORD_SEL_RW: ord_raddr = rword_reg;
            default:             ord_raddr = p_reg;
        endcase
    end

    // byte step of the compare, then length decides once the common part matches
    always_comb
    begin
        if (col_reg < cmp_n)
        begin
            if (char_rd_reg < pend_byte)
                sts.cmp = usw_pkg::CMP_LESS;
            else if (char_rd_reg > pend_byte)
                sts.cmp = usw_pkg::CMP_GREATER;
            else
                sts.cmp = usw_pkg::CMP_MATCH;
        end
        else if (len_rd_reg == plen_reg)
            sts.cmp = usw_pkg::CMP_EQUAL;
        else if (len_rd_reg < plen_reg)
            sts.cmp = usw_pkg::CMP_LESS;
        else
            sts.cmp = usw_pkg::CMP_GREATER;
    end

    assign sts.plen_zero  = (plen_reg == '0);
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(MAX_WORDS));
    assign sts.p_last     = (p_reg + CW'(1)) == count_reg;
    assign sts.wr_last    = (col_reg + LW'(1)) == plen_reg;
    assign sts.q_at_p     = (q_reg == p_reg);
    assign sts.pull_empty = !sorted_reg || (rword_reg >= count_reg);
    assign sts.out_valid  = out_valid_reg;
    assign sts.sorted     = sorted_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (cmd.char_wr)
            char_mem[caddr] <= pend_byte;
        char_rd_reg <= char_mem[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.len_wr)
            len_mem[count_reg[IW-1:0]] <= plen_reg;
        len_rd_reg <= len_mem[ord_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ord_wr)
            ord_mem[q_reg[IW-1:0]] <= cmd.ord_ins ? count_reg[IW-1:0] : ord_rd_reg;
        ord_rd_reg <= ord_mem[ord_raddr[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && (plen_reg < LW'(MAX_LEN)))
            pend_reg[plen_reg[PIW-1:0]] <= req_ch;
        if (cmd.ld_base)
            base_reg <= AW'(mul_in * MAX_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            count_reg     <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            col_reg       <= '0;
            rword_reg     <= '0;
            rchar_reg     <= '0;
            sorted_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                if (plen_reg < LW'(MAX_LEN))
                    plen_reg <= plen_reg + LW'(1);
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                p_reg   <= '0;
                col_reg <= '0;
            end
            if (cmd.next_word)
            begin
                p_reg   <= p_reg + CW'(1);
                col_reg <= '0;
            end
            if (cmd.col_inc)
                col_reg <= col_reg + LW'(1);
            if (cmd.q_init)
            begin
                q_reg   <= count_reg;
                col_reg <= '0;
            end
            if (cmd.q_dec)
                q_reg <= q_reg - CW'(1);
            if (cmd.commit)
                count_reg <= count_reg + CW'(1);
            if (cmd.set_drop)
                drop_reg <= 1'b1;
            if (cmd.fin)
            begin
                plen_reg <= '0;
                if (cmd.fin_sort)
                begin
                    sorted_reg <= 1'b1;
                    rword_reg  <= '0;
                    rchar_reg  <= '0;
                end
            end

            if (cmd.out_empty || cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_take)
                out_valid_reg <= 1'b0;
            if (cmd.out_empty)
            begin
                out_reg <= '{out_char: 8'd0, last_of_word: 1'b0, last_of_list: 1'b0,
                             empty_res: 1'b1, dropped: drop_reg};
            end
            if (cmd.out_load)
            begin
                out_reg.out_char      <= char_rd_reg;
                out_reg.last_of_word  <= rd_last;
                out_reg.last_of_list  <= rd_last && ((rword_reg + CW'(1)) == count_reg);
                out_reg.empty_res     <= 1'b0;
                out_reg.dropped       <= drop_reg;
                if (rd_last)
                begin
                    rword_reg <= rword_reg + CW'(1);
                    rchar_reg <= '0;
                end
                else
                    rchar_reg <= rchar_reg + LW'(1);
            end
        end
    end

endmodule
